// ----- sv/stpi_pkg.sv -----
// ----------------------------------------------------------------------------
// stpi_pkg: shared definitions for the sorted table with prime index
// Action and status codes, the cell command type and the shared value width.
// ----------------------------------------------------------------------------
package stpi_pkg;

   localparam int unsigned VALUE_W = 32;

   // Action codes carried on the request word.
   localparam logic [2:0] ACT_ADD        = 3'd0;
   localparam logic [2:0] ACT_REMOVE     = 3'd1;
   localparam logic [2:0] ACT_READ_ASC   = 3'd2;
   localparam logic [2:0] ACT_READ_SIDE  = 3'd3;
   localparam logic [2:0] ACT_READ_PRIME = 3'd4;

   // Status codes carried on the response word.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // Operation broadcast to every cell of a chain.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- sv/sorted_table_with_prime_index.sv -----
// ----------------------------------------------------------------------------
// sorted_table_with_prime_index: sorted value table with a prime sub-table
// Two rows of cells keep all values and the prime values in ascending order;
// a trial-division unit decides primality on add and remove.
// ----------------------------------------------------------------------------
//  channel | ports                                           | direction
//  req     | req_valid, req_stall, req_action/value/position | in (stall out)
//  rsp     | rsp_valid, rsp_stall, rsp_data/status/count/... | out (stall in)
//
// Reads and failing actions are answered from the checking step; add and
// successful remove run the primality unit, which tests odd divisors up to
// the square root of the value, and the cells then shift in the apply step.
// One word is in flight at a time; req_stall is high while a word is in work
// or a response waits. Reset clears the counts; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_table_with_prime_index #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_data,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_count,
   output logic [6:0]  rsp_prime_count
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned XW = CW + 6;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_PRIME = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  action_ff, action_in;
   logic [31:0] value_ff, value_in;
   logic [5:0]  pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pcount_ff, pcount_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_count_ff, rsp_count_in;
   logic [6:0]  rsp_pcount_ff, rsp_pcount_in;

   stpi_pkg::cell_cmd_type sorted_cmd, prime_cmd;
   logic [31:0] sorted_values [CAPACITY];
   logic [31:0] prime_values  [CAPACITY];
   logic        sorted_found, prime_found;
   logic        prime_start, prime_done, prime_is;
   logic        req_accept;
   logic [XW-1:0] pos_x, cnt_x, pcnt_x, side_x;

   assign req_stall       = (state_ff != S_IDLE) || rsp_valid_ff;
   assign req_accept      = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_prime_count = rsp_pcount_ff;

   // Read positions compared at a common width.
   assign pos_x  = XW'(pos_ff);
   assign cnt_x  = XW'(count_ff);
   assign pcnt_x = XW'(pcount_ff);
   assign side_x = pos_ff[0] ? (cnt_x - XW'(pos_ff[5:1]) - XW'(1)) : XW'(pos_ff[5:1]);

   // The two cell rows.
   stpi_chain #(.CAPACITY(CAPACITY), .CW(CW)) u_sorted (
      .clock  (clock),
      .cmd    (sorted_cmd),
      .len    (count_ff),
      .values (sorted_values),
      .found  (sorted_found)
   );

   stpi_chain #(.CAPACITY(CAPACITY), .CW(CW)) u_primes (
      .clock  (clock),
      .cmd    (prime_cmd),
      .len    (pcount_ff),
      .values (prime_values),
      .found  (prime_found)
   );

   stpi_prime u_prime (
      .clock    (clock),
      .reset    (reset),
      .start    (prime_start),
      .value    (value_ff),
      .done     (prime_done),
      .is_prime (prime_is)
   );

   // Control sequence and response formation.
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      pcount_in     = pcount_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_pcount_in = rsp_pcount_ff;
      prime_start   = 1'b0;
      sorted_cmd.op    = stpi_pkg::CELL_HOLD;
      sorted_cmd.value = value_ff;
      prime_cmd.op     = stpi_pkg::CELL_HOLD;
      prime_cmd.value  = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               action_in = req_action;
               value_in  = req_value;
               pos_in    = req_position;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            rsp_data_in   = '0;
            rsp_status_in = stpi_pkg::ST_OK;
            rsp_count_in  = 7'(count_ff);
            rsp_pcount_in = 7'(pcount_ff);
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            unique case (action_ff)
               stpi_pkg::ACT_ADD: begin
                  if (count_ff >= CAP_C) begin
                     rsp_status_in = stpi_pkg::ST_FULL;
                  end else begin
                     prime_start  = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_PRIME;
                  end
               end
               stpi_pkg::ACT_REMOVE: begin
                  if (!sorted_found) begin
                     rsp_status_in = stpi_pkg::ST_NOT_FOUND;
                  end else begin
                     prime_start  = 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_PRIME;
                  end
               end
               stpi_pkg::ACT_READ_ASC: begin
                  if (pos_x < cnt_x) begin
                     rsp_data_in = sorted_values[pos_x[IW-1:0]];
                  end else begin
                     rsp_status_in = stpi_pkg::ST_RANGE;
                  end
               end
               stpi_pkg::ACT_READ_SIDE: begin
                  if (pos_x < cnt_x) begin
                     rsp_data_in = sorted_values[side_x[IW-1:0]];
                  end else begin
                     rsp_status_in = stpi_pkg::ST_RANGE;
                  end
               end
               stpi_pkg::ACT_READ_PRIME: begin
                  if (pos_x < pcnt_x) begin
                     rsp_data_in = prime_values[pos_x[IW-1:0]];
                  end else begin
                     rsp_status_in = stpi_pkg::ST_RANGE;
                  end
               end
               default: begin
                  rsp_status_in = stpi_pkg::ST_OK;
               end
            endcase
         end
         S_PRIME: begin
            if (prime_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (action_ff == stpi_pkg::ACT_ADD) begin
               sorted_cmd.op = stpi_pkg::CELL_INSERT;
               count_in      = count_ff + CW'(1);
               if (prime_is && pcount_ff < CAP_C) begin
                  prime_cmd.op = stpi_pkg::CELL_INSERT;
                  pcount_in    = pcount_ff + CW'(1);
               end
            end else begin
               sorted_cmd.op = stpi_pkg::CELL_DELETE;
               count_in      = count_ff - CW'(1);
               if (prime_is && prime_found) begin
                  prime_cmd.op = stpi_pkg::CELL_DELETE;
                  pcount_in    = pcount_ff - CW'(1);
               end
            end
            rsp_data_in   = '0;
            rsp_status_in = stpi_pkg::ST_OK;
            rsp_count_in  = 7'(count_in);
            rsp_pcount_in = 7'(pcount_in);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_pcount_ff <= rsp_pcount_in;
   end

   // The fill level never passes the capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("table count exceeds capacity");

   // The prime table never holds more entries than the main table.
   a_prime_le: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= count_ff)
      else $error("prime count exceeds table count");

   // An accepted word always moves on to the checking step.
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_CHECK)
      else $error("accepted word not checked");

   // A full report only comes from a table at capacity.
   a_full_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == stpi_pkg::ST_FULL) |-> count_ff == CAP_C)
      else $error("full reported below capacity");

endmodule

// ----- sv/stpi_cell.sv -----
// ----------------------------------------------------------------------------
// stpi_cell: one entry of a sorted chain
// Holds one value, compares it with the broadcast value and shifts towards
// or away from its neighbours on an insert or a delete.
// ----------------------------------------------------------------------------
module stpi_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CW    = 7
) (
   input  logic                          clock,
   input  stpi_pkg::cell_cmd_type        cmd,
   input  logic [CW-1:0]                 len,
   input  logic [stpi_pkg::VALUE_W-1:0]  left_value,
   input  logic                          left_lt,
   input  logic [stpi_pkg::VALUE_W-1:0]  right_value,
   output logic [stpi_pkg::VALUE_W-1:0]  value,
   output logic                          lt,
   output logic                          eq
);

   localparam logic [CW-1:0] POS = CW'(INDEX);

   logic [stpi_pkg::VALUE_W-1:0] value_ff;
   logic [stpi_pkg::VALUE_W-1:0] value_in;
   logic                         live;

   // The cell takes part only while it lies below the fill level.
   assign live  = POS < len;
   assign lt    = live && ($signed(value_ff) < $signed(cmd.value));
   assign eq    = live && (value_ff == cmd.value);
   assign value = value_ff;

   // An insert lands after the last smaller entry; later cells take their left
   // neighbour. A delete pulls every cell from the first equal entry onwards.
   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         stpi_pkg::CELL_INSERT: begin
            if (!lt) begin
               value_in = left_lt ? cmd.value : left_value;
            end
         end
         stpi_pkg::CELL_DELETE: begin
            if (!lt) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- sv/stpi_chain.sv -----
// ----------------------------------------------------------------------------
// stpi_chain: row of cells forming one sorted table
// Wires the cells to their neighbours and gathers the match flag.
// ----------------------------------------------------------------------------
module stpi_chain #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned CW       = 7
) (
   input  logic                          clock,
   input  stpi_pkg::cell_cmd_type        cmd,
   input  logic [CW-1:0]                 len,
   output logic [stpi_pkg::VALUE_W-1:0]  values [CAPACITY],
   output logic                          found
);

   logic [CAPACITY-1:0] lt;
   logic [CAPACITY-1:0] eq;

   // The table holds an equal entry when any live cell matches.
   assign found = |eq;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [stpi_pkg::VALUE_W-1:0] left_value;
      logic [stpi_pkg::VALUE_W-1:0] right_value;
      logic                         left_lt;

      // The first cell sees an empty, smaller neighbour on its left.
      if (i == 0) begin : g_first
         assign left_value = cmd.value;
         assign left_lt    = 1'b1;
      end else begin : g_mid
         assign left_value = values[i-1];
         assign left_lt    = lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = values[i];
      end else begin : g_inner
         assign right_value = values[i+1];
      end

      stpi_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .len         (len),
         .left_value  (left_value),
         .left_lt     (left_lt),
         .right_value (right_value),
         .value       (values[i]),
         .lt          (lt[i]),
         .eq          (eq[i])
      );
   end

endmodule

// ----- sv/stpi_prime.sv -----
// ----------------------------------------------------------------------------
// stpi_prime: trial-division primality unit
// Tests odd divisors from three upwards until the divisor squared passes the
// value; each divisor works through the dividend eight remainder bits at a time.
// ----------------------------------------------------------------------------
module stpi_prime (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [stpi_pkg::VALUE_W-1:0]  value,
   output logic                          done,
   output logic                          is_prime
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        prime_ff, prime_in;
   logic [31:0] n_ff, n_in;
   logic [15:0] d_ff, d_in;
   logic [32:0] dsq_ff, dsq_in;
   logic [15:0] rem_ff, rem_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  chunk;
   logic [15:0] rem_step;

   assign done     = done_ff;
   assign is_prime = prime_ff;

   // Select the next eight dividend bits, most significant first.
   always_comb begin
      unique case (phase_ff)
         2'd0:    chunk = n_ff[31:24];
         2'd1:    chunk = n_ff[23:16];
         2'd2:    chunk = n_ff[15:8];
         default: chunk = n_ff[7:0];
      endcase
   end

   // Eight restoring remainder steps; the remainder stays below the divisor.
   always_comb begin
      logic [16:0] r;
      r = {1'b0, rem_ff};
      for (int k = 7; k >= 0; k--) begin
         r = {r[15:0], chunk[k]};
         if (r >= {1'b0, d_ff}) begin
            r = r - {1'b0, d_ff};
         end
      end
      rem_step = r[15:0];
   end

   // Sequencer of the divisor loop.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      prime_in = prime_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      dsq_in   = dsq_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      if (start) begin
         n_in = value;
         priority if (value[31] || value < 32'd2) begin
            done_in  = 1'b1;
            prime_in = 1'b0;
         end else if (value == 32'd2) begin
            done_in  = 1'b1;
            prime_in = 1'b1;
         end else if (!value[0]) begin
            done_in  = 1'b1;
            prime_in = 1'b0;
         end else begin
            busy_in  = 1'b1;
            d_in     = 16'd3;
            dsq_in   = 33'd9;
            rem_in   = '0;
            phase_in = '0;
         end
      end else if (busy_ff) begin
         if (phase_ff == 2'd0 && dsq_ff > {1'b0, n_ff}) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            prime_in = 1'b1;
         end else begin
            rem_in   = rem_step;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (rem_step == '0) begin
                  busy_in  = 1'b0;
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else begin
                  // (d+2)^2 = d^2 + 4d + 4
                  d_in   = d_ff + 16'd2;
                  dsq_in = dsq_ff + {15'd0, d_ff, 2'b00} + 33'd4;
                  rem_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prime_ff <= prime_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      dsq_ff   <= dsq_in;
      rem_ff   <= rem_in;
      phase_ff <= phase_in;
   end

endmodule

// ----- tb/sv/sorted_table_with_prime_index_test.sv -----
// ----------------------------------------------------------------------------
// sorted_table_with_prime_index_test: self-checking bench for the sorted table
// Drives add, remove, read and undefined action words with random idling on
// both channels, predicts every response from a behavioural copy of both
// tables and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module sorted_table_with_prime_index_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;

   typedef struct {
      logic [31:0] data;
      logic [1:0]  status;
      logic [6:0]  count;
      logic [6:0]  prime_count;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = stpi_pkg::ACT_ADD;
   logic [31:0] req_value = '0;
   logic [5:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_data;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_count;
   logic [6:0]  rsp_prime_count;

   // Behavioural copy of the two tables.
   logic [31:0] model_values [TABLE_DEPTH];
   logic [31:0] model_primes [TABLE_DEPTH];
   int          model_count = 0;
   int          model_prime_count = 0;

   reply_type   replies_due [$];
   int          errors = 0;
   bit          calm = 1'b0;

   sorted_table_with_prime_index DUT (.*);

   always #5 clock = ~clock;

   // Receiver side: random stalls unless a calm stretch is running.
   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
   end

   function automatic bit is_prime(logic [31:0] v);
      longint d;
      if (v[31] || v < 2) return 1'b0;
      for (d = 2; d * d <= longint'(v); d++) begin
         if (v % d[31:0] == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Inserts before the first entry not smaller, in signed order.
   task automatic table_insert(ref logic [31:0] tab [TABLE_DEPTH], ref int len,
                               input logic [31:0] v);
      int at;
      at = 0;
      while (at < len && $signed(tab[at]) < $signed(v)) at++;
      for (int k = len; k > at; k--) tab[k] = tab[k-1];
      tab[at] = v;
      len++;
   endtask

   task automatic table_delete(ref logic [31:0] tab [TABLE_DEPTH], ref int len,
                               input logic [31:0] v, output bit found);
      int at;
      at = 0;
      while (at < len && tab[at] != v) at++;
      found = (at < len);
      if (found) begin
         for (int k = at; k + 1 < len; k++) tab[k] = tab[k+1];
         len--;
      end
   endtask

   // Applies one accepted word to the tables and returns the response due.
   task automatic apply_word(logic [2:0] act, logic [31:0] v, logic [5:0] pos,
                             output reply_type r);
      bit found;
      r.data = '0;
      r.status = stpi_pkg::ST_OK;
      case (act)
         stpi_pkg::ACT_ADD: begin
            if (model_count >= TABLE_DEPTH) r.status = stpi_pkg::ST_FULL;
            else begin
               table_insert(model_values, model_count, v);
               if (is_prime(v) && model_prime_count < TABLE_DEPTH)
                  table_insert(model_primes, model_prime_count, v);
            end
         end
         stpi_pkg::ACT_REMOVE: begin
            table_delete(model_values, model_count, v, found);
            if (!found) r.status = stpi_pkg::ST_NOT_FOUND;
            else if (is_prime(v)) table_delete(model_primes, model_prime_count, v, found);
         end
         stpi_pkg::ACT_READ_ASC: begin
            if (pos < model_count) r.data = model_values[pos];
            else r.status = stpi_pkg::ST_RANGE;
         end
         stpi_pkg::ACT_READ_SIDE: begin
            if (pos < model_count)
               r.data = pos[0] ? model_values[model_count - 1 - (pos >> 1)]
                               : model_values[pos >> 1];
            else r.status = stpi_pkg::ST_RANGE;
         end
         stpi_pkg::ACT_READ_PRIME: begin
            if (pos < model_prime_count) r.data = model_primes[pos];
            else r.status = stpi_pkg::ST_RANGE;
         end
         default: ;
      endcase
      r.count = model_count[6:0];
      r.prime_count = model_prime_count[6:0];
   endtask

   // Sends one word, with random idle cycles in front unless calm.
   task automatic send_word(logic [2:0] act, logic [31:0] v, logic [5:0] pos);
      reply_type r;
      if (!calm) begin
         while ($urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= v;
      req_position <= pos;
      // Stall only moves on rising edges, so the falling edge shows the verdict.
      do begin
         @(negedge clock);
      end while (req_stall);
      apply_word(act, v, pos, r);
      replies_due.insert(replies_due.size(), r);
      @(posedge clock);
   endtask

   // Compares each accepted response with the oldest one due.
   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected response data %h status %0d", $time,
                     rsp_data, rsp_status);
            errors++;
         end else begin
            e = replies_due.pop_front();
            if (rsp_data !== e.data) begin
               $display("%0t: data expected %h actual %h", $time, e.data, rsp_data);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status,
                        rsp_status);
               errors++;
            end
            if (rsp_count !== e.count) begin
               $display("%0t: count expected %0d actual %0d", $time, e.count, rsp_count);
               errors++;
            end
            if (rsp_prime_count !== e.prime_count) begin
               $display("%0t: prime count expected %0d actual %0d", $time,
                        e.prime_count, rsp_prime_count);
               errors++;
            end
         end
      end
   end

   // Picks a value that keeps the primality unit quick: small, negative or even.
   function automatic logic [31:0] quick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom_range(60);
      if (sel < 85) return {1'b1, 31'($urandom)};
      return {1'b0, 30'($urandom), 1'b0};
   endfunction

   task automatic test_edges();
      send_word(stpi_pkg::ACT_READ_ASC, 32'd0, 6'd0);
      send_word(stpi_pkg::ACT_REMOVE, 32'd5, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'h7FFF_FFFF, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'h8000_0000, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'd2, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'd2, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'd1, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'd0, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'hFFFF_FFFF, 6'd0);
      send_word(stpi_pkg::ACT_ADD, 32'd9, 6'd0);
      send_word(stpi_pkg::ACT_READ_ASC, 32'd0, 6'd7);
      send_word(stpi_pkg::ACT_READ_SIDE, 32'd0, 6'd1);
      send_word(stpi_pkg::ACT_READ_SIDE, 32'd0, 6'd6);
      send_word(stpi_pkg::ACT_READ_PRIME, 32'd0, 6'd2);
      send_word(stpi_pkg::ACT_READ_PRIME, 32'd0, 6'd3);
      send_word(stpi_pkg::ACT_READ_ASC, 32'hFFFF_FFFF, 6'd63);
      send_word(3'd5, 32'd7, 6'd1);
      send_word(3'd6, 32'd7, 6'd1);
      send_word(3'd7, 32'd7, 6'd1);
      send_word(stpi_pkg::ACT_REMOVE, 32'd2, 6'd0);
      send_word(stpi_pkg::ACT_REMOVE, 32'h7FFF_FFFF, 6'd0);
      send_word(stpi_pkg::ACT_REMOVE, 32'd4, 6'd0);
      send_word(stpi_pkg::ACT_READ_PRIME, 32'd0, 6'd0);
   endtask

   // Fills the table past capacity with no idling, then reads position 63 in ascending and side order.
   task automatic test_full_table();
      calm = 1'b1;
      while (model_count < TABLE_DEPTH)
         send_word(stpi_pkg::ACT_ADD, quick_value(), 6'($urandom));
      send_word(stpi_pkg::ACT_ADD, 32'd3, 6'd0);
      send_word(stpi_pkg::ACT_READ_ASC, 32'd0, 6'd63);
      send_word(stpi_pkg::ACT_READ_SIDE, 32'd0, 6'd63);
      calm = 1'b0;
   endtask

   // Random mix of actions; removes mostly hit stored values.
   task automatic test_random_mix(int n, bit quiet);
      int sel;
      logic [31:0] v;
      calm = quiet;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         v = quick_value();
         if (sel < 30) send_word(stpi_pkg::ACT_ADD, v, 6'($urandom));
         else if (sel < 55) begin
            if (model_count > 0 && $urandom_range(3) != 0)
               v = model_values[$urandom_range(model_count - 1)];
            send_word(stpi_pkg::ACT_REMOVE, v, 6'($urandom));
         end else if (sel < 68)
            send_word(stpi_pkg::ACT_READ_ASC, v, 6'($urandom_range(model_count + 2)));
         else if (sel < 81)
            send_word(stpi_pkg::ACT_READ_SIDE, v, 6'($urandom_range(model_count + 2)));
         else if (sel < 95)
            send_word(stpi_pkg::ACT_READ_PRIME, v,
                      6'($urandom_range(model_prime_count + 2)));
         else send_word(3'($urandom_range(7, 5)), v, 6'($urandom));
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_full_table();
      test_random_mix(16, 1'b0);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
sv/stpi_pkg.sv
sv/stpi_cell.sv
sv/stpi_chain.sv
sv/stpi_prime.sv
sv/sorted_table_with_prime_index.sv
tb/sv/sorted_table_with_prime_index_test.sv
